FILE: hw/rtl/cmgt_pkg.sv
// package for the civil / mjd / gnss time converter
// beat types and calendar constants, no dependencies
package cmgt_pkg;

	localparam logic [1:0] ACT_CIVIL = 2'd0;
	localparam logic [1:0] ACT_MJD   = 2'd1;
	localparam logic [1:0] ACT_WEEK  = 2'd2;

	localparam logic [16:0] EPOCH_RESET = 17'd44244;
	localparam logic [16:0] MJD_LOW     = 17'd15385;
	localparam logic [16:0] MJD_HIGH    = 17'd88068;
	localparam logic [29:0] NS_MAX      = 30'd999999999;

	typedef struct packed {
		logic [1:0]  action;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [29:0] nanosecond;
		logic [16:0] mjd_day;
		logic [16:0] sec_of_day;
		logic [12:0] gnss_week;
		logic [19:0] sec_of_week;
	} in_beat_t;

	typedef struct packed {
		logic [11:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [5:0]  out_second;
		logic [17:0] out_mjd;
		logic [16:0] out_sec_of_day;
		logic [29:0] out_nanosecond;
		logic        status;
	} out_beat_t;

	// floor(306001*x/10000) for x in 4..15
	function automatic logic [9:0] month_days(input logic [3:0] x);
		logic [9:0] r;
		case (x)
			4'd4:    r = 10'd122;
			4'd5:    r = 10'd153;
			4'd6:    r = 10'd183;
			4'd7:    r = 10'd214;
			4'd8:    r = 10'd244;
			4'd9:    r = 10'd275;
			4'd10:   r = 10'd306;
			4'd11:   r = 10'd336;
			4'd12:   r = 10'd367;
			4'd13:   r = 10'd397;
			4'd14:   r = 10'd428;
			4'd15:   r = 10'd459;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/civil_mjd_gnss_time_converter_core.sv
// civil / mjd / gnss week time converter, top level
// done follows start through the valid pipe, one beat accepted every cycle
// busy is always low; done strobes each result for one cycle
// arst_n clears the valid pipe and loads the epoch register with the gps epoch
// uses cmgt_pkg, cmgt_civil_path, cmgt_mjd_path
module civil_mjd_gnss_time_converter_core import cmgt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_beat_t  in_beat,
	output logic      done,
	output out_beat_t out_beat,
	input  logic      cfg_we,
	input  logic [16:0] cfg_wdata
);
	logic [16:0] epoch_q;
	logic [2:0]  vld;
	logic [1:0]  act_s1, act_s2, act_s3;
	logic        bad_s1, bad_s2, bad_s3;
	logic [29:0] ns_s1, ns_s2, ns_s3;
	// week path registers
	logic [17:0] wk_s1, wk_s2, wk_s3;
	logic [19:0] sow_s1;
	logic [2:0]  dow_s2;
	logic [16:0] wsod_s2, wsod_s3;
	logic        bad;
	logic [2:0]  dow;
	logic [17:0] c_mjd;
	logic [16:0] c_sod;
	logic [11:0] m_yr;
	logic [3:0]  m_mo;
	logic [4:0]  m_dy, m_hr;
	logic [5:0]  m_mi, m_se;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= EPOCH_RESET;
			vld     <= '0;
		end else begin
			if (cfg_we) epoch_q <= cfg_wdata;
			vld <= {vld[1:0], start};
		end
	end

	// range checks per action
	always_comb begin
		bad = in_beat.nanosecond > NS_MAX;
		case (in_beat.action)
			ACT_CIVIL: bad = bad || in_beat.year < 12'd1901 || in_beat.year > 12'd2099
				|| in_beat.month < 4'd1 || in_beat.month > 4'd12 || in_beat.day == 5'd0
				|| in_beat.hour > 5'd23 || in_beat.minute > 6'd59 || in_beat.second > 6'd59;
			ACT_MJD: bad = bad || in_beat.mjd_day < MJD_LOW || in_beat.mjd_day > MJD_HIGH
				|| in_beat.sec_of_day > 17'd86399;
			ACT_WEEK: bad = bad || in_beat.sec_of_week > 20'd604799 || epoch_q > MJD_HIGH;
			default: bad = 1'b1;
		endcase
	end

	// day of week: small compare chain on six boundaries
	always_comb begin
		dow = 3'd0;
		for (int k = 1; k < 7; k++)
			if (sow_s1 >= 20'(k * 86400)) dow = 3'(k);
	end

	always_ff @(posedge clk) begin
		act_s1 <= in_beat.action; bad_s1 <= bad; ns_s1 <= in_beat.nanosecond;
		wk_s1  <= 18'(epoch_q) + 18'(in_beat.gnss_week) * 18'd7;
		sow_s1 <= in_beat.sec_of_week;
		act_s2 <= act_s1; bad_s2 <= bad_s1; ns_s2 <= ns_s1;
		wk_s2 <= wk_s1; dow_s2 <= dow;
		wsod_s2 <= 17'(sow_s1 - 20'(dow) * 20'd86400);
		act_s3 <= act_s2; bad_s3 <= bad_s2; ns_s3 <= ns_s2;
		wk_s3 <= wk_s2 + 18'(dow_s2);
		wsod_s3 <= wsod_s2;
	end

	cmgt_civil_path u_civil (
		.clk(clk), .year(in_beat.year), .month(in_beat.month), .day(in_beat.day),
		.hour(in_beat.hour), .minute(in_beat.minute), .second(in_beat.second),
		.mjd(c_mjd), .sod(c_sod)
	);

	cmgt_mjd_path u_mjd (
		.clk(clk), .mjd_day(in_beat.mjd_day), .sec_of_day(in_beat.sec_of_day),
		.yr(m_yr), .mo(m_mo), .dy(m_dy), .hr(m_hr), .mi(m_mi), .se(m_se)
	);

	// output select; fields an action does not make stay zero
	always_comb begin
		out_beat = '0;
		out_beat.out_nanosecond = ns_s3;
		out_beat.status = bad_s3;
		if (!bad_s3) begin
			case (act_s3)
				ACT_CIVIL: begin
					out_beat.out_mjd = c_mjd;
					out_beat.out_sec_of_day = c_sod;
				end
				ACT_MJD: begin
					out_beat.out_year = m_yr; out_beat.out_month = m_mo;
					out_beat.out_day = m_dy; out_beat.out_hour = m_hr;
					out_beat.out_minute = m_mi; out_beat.out_second = m_se;
				end
				ACT_WEEK: begin
					out_beat.out_mjd = wk_s3;
					out_beat.out_sec_of_day = wsod_s3;
				end
				default: out_beat.status = 1'b1;
			endcase
		end
	end

	assign done = vld[2];
endmodule

FILE: hw/rtl/cmgt_civil_path.sv
// civil date to mjd, three stages
// uses cmgt_pkg
module cmgt_civil_path import cmgt_pkg::*; (
	input  logic        clk,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	output logic [17:0] mjd,
	output logic [16:0] sod
);
	logic [11:0] y_s1;
	logic [9:0]  md_s1;
	logic [4:0]  d_s1;
	logic [16:0] hs_s1, ms_s1;
	logic [5:0]  se_s1;
	logic [19:0] yd_s2;
	logic [10:0] rd_s2;
	logic [16:0] sod_s2;

	always_ff @(posedge clk) begin
		if (month <= 4'd2) begin
			y_s1  <= year - 12'd1;
			md_s1 <= month_days(month + 4'd13);
		end else begin
			y_s1  <= year;
			md_s1 <= month_days(month + 4'd1);
		end
		d_s1  <= day;
		hs_s1 <= 17'(hour) * 17'd3600;
		ms_s1 <= 17'(minute) * 17'd60;
		se_s1 <= second;
		// product needs 22 bits before the quarter
		yd_s2  <= 20'((22'(y_s1) * 22'd1461) >> 2);
		rd_s2  <= 11'(md_s1) + 11'(d_s1);
		sod_s2 <= hs_s1 + ms_s1 + 17'(se_s1);
		mjd <= 18'(yd_s2 + 20'(rd_s2) - 20'd679019);
		sod <= sod_s2;
	end
endmodule

FILE: hw/rtl/cmgt_mjd_path.sv
// mjd to civil date, three stages, constant divides by reciprocal
// uses cmgt_pkg
module cmgt_mjd_path import cmgt_pkg::*; (
	input  logic        clk,
	input  logic [16:0] mjd_day,
	input  logic [16:0] sec_of_day,
	output logic [11:0] yr,
	output logic [3:0]  mo,
	output logic [4:0]  dy,
	output logic [4:0]  hr,
	output logic [5:0]  mi,
	output logic [5:0]  se
);
	// 40*(2400001+1537) - 4884
	localparam logic [26:0] NUM_BIAS = 27'd96056636;
	localparam logic [21:0] B_BIAS   = 22'd2401538;
	// ceil(2^41/14610), ceil(2^29/3600), ceil(2^23/60)
	localparam logic [27:0] RCP_C = 28'd150514939;
	localparam logic [17:0] RCP_H = 18'd149131;
	localparam logic [17:0] RCP_M = 18'd139811;

	logic [21:0] b_s1, b_s2;
	logic [26:0] num_s1;
	logic [16:0] sod_s1;
	logic [5:0]  h_s1;
	logic [11:0] tm_s1;
	logic [12:0] c_s2;
	logic [4:0]  h_s2;
	logic [5:0]  m_s2, s_s2;
	logic [34:0] h_prod, tm_prod;
	logic [54:0] c_prod;
	logic [23:0] c1461;
	logic [21:0] d;
	logic [9:0]  bd;
	logic [3:0]  e;

	// stage 1: hours and total minutes of the day
	always_comb begin
		h_prod  = 35'(sec_of_day) * 35'(RCP_H);
		tm_prod = 35'(sec_of_day) * 35'(RCP_M);
	end

	// stage 2: year count c = floor(num / 14610)
	always_comb begin
		c_prod = 55'(num_s1) * 55'(RCP_C);
	end

	// stage 3: day of year from march, month index e
	always_comb begin
		c1461 = 24'(c_s2) * 24'd1461;
		d     = 22'(c1461 >> 2);
		bd    = 10'(b_s2 - d);
		e = 4'd4;
		for (int k = 5; k <= 15; k++)
			if (bd > month_days(4'(k))) e = 4'(k);
	end

	always_ff @(posedge clk) begin
		b_s1   <= 22'(mjd_day) + B_BIAS;
		num_s1 <= 27'(mjd_day) * 27'd40 + NUM_BIAS;
		sod_s1 <= sec_of_day;
		h_s1   <= 6'(h_prod >> 29);
		tm_s1  <= 12'(tm_prod >> 23);
		c_s2 <= 13'(c_prod >> 41);
		b_s2 <= b_s1;
		h_s2 <= 5'(h_s1);
		m_s2 <= 6'(tm_s1 - 12'(h_s1) * 12'd60);
		s_s2 <= 6'(sod_s1 - 17'(tm_s1) * 17'd60);
		if (e >= 4'd14) begin
			mo <= e - 4'd13;
			yr <= 12'(c_s2 - 13'd4715);
		end else begin
			mo <= e - 4'd1;
			yr <= 12'(c_s2 - 13'd4716);
		end
		dy <= 5'(bd - month_days(e));
		hr <= h_s2; mi <= m_s2; se <= s_s2;
	end
endmodule

FILE: tb/testbench.sv
// testbench for civil_mjd_gnss_time_converter_core: random and directed conversion beats
// checked against an in-bench calendar predictor; depends on cmgt_pkg and the rtl
`timescale 1ns / 1ps

import cmgt_pkg::*;

// in-order store of predicted result beats with mismatch accounting
class conv_scoreboard;
	out_beat_t pending[$];
	int        n_err;
	int        n_seen;

	// note an accepted input beat by its predicted result
	function void note_input(out_beat_t pred);
		pending = {pending, pred};
	endfunction

	function void check_result(out_beat_t got);
		out_beat_t want;
		n_seen++;
		if (pending.size() == 0) begin
			n_err++;
			if (n_err <= 10)
				$display("unexpected result beat %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			n_err++;
			if (n_err <= 10)
				$display("mismatch: expected y%0d m%0d d%0d %0d:%0d:%0d mjd %0d sod %0d ns %0d st %0d, got y%0d m%0d d%0d %0d:%0d:%0d mjd %0d sod %0d ns %0d st %0d",
					want.out_year, want.out_month, want.out_day, want.out_hour,
					want.out_minute, want.out_second, want.out_mjd, want.out_sec_of_day,
					want.out_nanosecond, want.status,
					got.out_year, got.out_month, got.out_day, got.out_hour,
					got.out_minute, got.out_second, got.out_mjd, got.out_sec_of_day,
					got.out_nanosecond, got.status);
		end
	endfunction
endclass

module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int IN_BITS = $bits(in_beat_t);

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_beat_t    in_beat;
	logic        done;
	out_beat_t   out_beat;
	logic        cfg_we;
	logic [16:0] cfg_wdata;

	// shadow of the epoch register
	logic [16:0] epoch_shadow;
	conv_scoreboard sb;
	int n_beats;
	int n_epochs;
	int idle_cycles;

	civil_mjd_gnss_time_converter_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_beat(in_beat),
		.done(done), .out_beat(out_beat), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	// predicted result of one conversion beat
	function automatic out_beat_t convert_time(in_beat_t b, logic [16:0] epoch);
		out_beat_t r;
		logic      bad;
		longint    y, m, mjd, bb, c, d, e, mo, sod, dow;
		r = '0;
		bad = (b.nanosecond > NS_MAX);
		case (b.action)
			ACT_CIVIL: begin
				bad = bad || b.year < 1901 || b.year > 2099 || b.month < 1 || b.month > 12
					|| b.day < 1 || b.hour > 23 || b.minute > 59 || b.second > 59;
				if (!bad) begin
					y = longint'(b.year);
					m = longint'(b.month);
					if (m <= 2) begin
						y = y - 1;
						m = m + 12;
					end
					mjd = (1461 * y) / 4 + (306001 * (m + 1)) / 10000 + longint'(b.day)
						- 679019;
					r.out_mjd = mjd[17:0];
					sod = longint'(b.hour) * 3600 + longint'(b.minute) * 60
						+ longint'(b.second);
					r.out_sec_of_day = sod[16:0];
				end
			end
			ACT_MJD: begin
				bad = bad || b.mjd_day < MJD_LOW || b.mjd_day > MJD_HIGH
					|| b.sec_of_day >= 86400;
				if (!bad) begin
					bb = longint'(b.mjd_day) + 2400001 + 1537;
					c = (40 * bb - 4884) / 14610;
					d = (1461 * c) / 4;
					e = (10000 * (bb - d)) / 306001;
					mo = e - 1 - 12 * (e / 14);
					y = c - 4715 - (7 + mo) / 10;
					mjd = bb - d - (306001 * e) / 10000;
					sod = longint'(b.sec_of_day);
					r.out_year = y[11:0];
					r.out_month = mo[3:0];
					r.out_day = mjd[4:0];
					r.out_hour = 5'(sod / 3600);
					r.out_minute = 6'((sod % 3600) / 60);
					r.out_second = 6'(sod % 60);
				end
			end
			ACT_WEEK: begin
				bad = bad || b.sec_of_week > 604799 || epoch > MJD_HIGH;
				if (!bad) begin
					dow = longint'(b.sec_of_week) / 86400;
					mjd = longint'(epoch) + longint'(b.gnss_week) * 7 + dow;
					r.out_mjd = mjd[17:0];
					sod = longint'(b.sec_of_week) - dow * 86400;
					r.out_sec_of_day = sod[16:0];
				end
			end
			default: bad = 1'b1;
		endcase
		if (bad)
			r = '0;
		r.out_nanosecond = b.nanosecond;
		r.status = bad;
		return r;
	endfunction

	// result side: the receiver always takes the beat
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(out_beat);
	end

	// watchdog on cycles where no beat moves either way
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("watchdog expired");
			$display("testbench: FAIL");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 50)
			return 0;
		else if (p < 92)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 8);
	endfunction

	task automatic send_beat(in_beat_t b);
		int g;
		g = gap_len();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
		start <= 1'b1;
		in_beat <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_input(convert_time(b, epoch_shadow));
		n_beats++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		// the pipe is empty after this
		repeat (6) @(posedge clk);
	endtask

	// epoch writes only happen once the pipe is empty
	task automatic write_epoch(logic [16:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		epoch_shadow = v;
		n_epochs++;
	endtask

	function automatic in_beat_t rand_noise();
		in_beat_t b;
		b = in_beat_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
		return b;
	endfunction

	// well-formed beat for the given action with random content, random junk elsewhere
	function automatic in_beat_t rand_good(logic [1:0] act);
		in_beat_t b;
		b = rand_noise();
		b.action = act;
		b.nanosecond = 30'($urandom_range(999999999));
		b.year = 12'($urandom_range(2099, 1901));
		b.month = 4'($urandom_range(12, 1));
		b.day = 5'($urandom_range(31, 1));
		b.hour = 5'($urandom_range(23));
		b.minute = 6'($urandom_range(59));
		b.second = 6'($urandom_range(59));
		b.mjd_day = 17'($urandom_range(88068, 15385));
		b.sec_of_day = 17'($urandom_range(86399));
		b.sec_of_week = 20'($urandom_range(604799));
		return b;
	endfunction

	// a good beat with one field, or minute and second together, pushed out of its range
	function automatic in_beat_t rand_broken();
		in_beat_t b;
		b = rand_good(2'($urandom_range(2)));
		case ($urandom_range(9))
			0: b.year = 12'($urandom_range(1900));
			1: b.year = 12'($urandom_range(4095, 2100));
			2: b.month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
			3: b.day = 5'd0;
			4: b.hour = 5'($urandom_range(31, 24));
			5: begin
				b.minute = 6'($urandom_range(63, 60));
				b.second = 6'($urandom_range(63, 60));
			end
			6: b.mjd_day = $urandom_range(1) ? 17'($urandom_range(15384))
				: 17'($urandom_range(131071, 88069));
			7: b.sec_of_day = 17'($urandom_range(131071, 86400));
			8: b.sec_of_week = 20'($urandom_range(1048575, 604800));
			default: b.nanosecond = 30'($urandom_range(30'h3fffffff, 1000000000));
		endcase
		return b;
	endfunction

	task automatic run_directed();
		in_beat_t b;
		// civil extremes, including a day past month end
		b = rand_good(ACT_CIVIL);
		b.year = 12'd1901; b.month = 4'd1; b.day = 5'd1; b.hour = 5'd0; b.minute = 6'd0;
		b.second = 6'd0;
		b.nanosecond = 30'd0;
		send_beat(b);
		b.year = 12'd2099; b.month = 4'd12; b.day = 5'd31; b.hour = 5'd23;
		b.minute = 6'd59; b.second = 6'd59; b.nanosecond = NS_MAX;
		send_beat(b);
		b.year = 12'd2001; b.month = 4'd2; b.day = 5'd31;
		send_beat(b);
		b.year = 12'd2000; b.month = 4'd2; b.day = 5'd29;
		send_beat(b);
		b.year = 12'd1900;
		send_beat(b);
		b.year = 12'd2000; b.month = 4'd0;
		send_beat(b);
		b.month = 4'd13; send_beat(b);
		b.month = 4'd3; b.day = 5'd0; send_beat(b);
		b.day = 5'd1; b.hour = 5'd24; send_beat(b);
		b.hour = 5'd0; b.minute = 6'd60; send_beat(b);
		b.minute = 6'd0; b.second = 6'd60; send_beat(b);
		// mjd extremes
		b = rand_good(ACT_MJD);
		b.mjd_day = MJD_LOW; b.sec_of_day = 17'd0; send_beat(b);
		b.mjd_day = MJD_HIGH; b.sec_of_day = 17'd86399; send_beat(b);
		b.mjd_day = MJD_LOW - 17'd1; send_beat(b);
		b.mjd_day = MJD_HIGH + 17'd1; send_beat(b);
		b.mjd_day = 17'd51544; b.sec_of_day = 17'd86400; send_beat(b);
		// week extremes
		b = rand_good(ACT_WEEK);
		b.gnss_week = 13'd0; b.sec_of_week = 20'd0; send_beat(b);
		b.gnss_week = 13'h1fff; b.sec_of_week = 20'd604799; send_beat(b);
		b.sec_of_week = 20'd604800; send_beat(b);
		b.sec_of_week = 20'hfffff; send_beat(b);
		// unused action, all-ones nanosecond passes through
		b = rand_noise();
		b.action = 2'd3; send_beat(b);
		b = rand_good(ACT_MJD);
		b.nanosecond = 30'h3fffffff; send_beat(b);
		b = '1; send_beat(b);
		b = '0; send_beat(b);
	endtask

	task automatic run_random(int count);
		int p;
		repeat (count) begin
			p = $urandom_range(99);
			if (p < 75)
				send_beat(rand_good(2'($urandom_range(2))));
			else if (p < 90)
				send_beat(rand_broken());
			else
				send_beat(rand_noise());
		end
	endtask

	initial begin
		sb = new();
		n_beats = 0;
		n_epochs = 0;
		idle_cycles = 0;
		epoch_shadow = EPOCH_RESET;
		start = 1'b0;
		in_beat = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset epoch first, then the other constellations and the extremes
		run_directed();
		run_random(350);
		write_epoch(17'd53736);
		run_random(300);
		write_epoch(17'd51412);
		run_random(300);
		write_epoch(17'd0);
		run_random(250);
		write_epoch(MJD_HIGH);
		run_random(250);
		write_epoch(MJD_HIGH + 17'd1);
		run_random(150);
		write_epoch(17'h1ffff);
		run_random(100);
		write_epoch(17'($urandom_range(88068)));
		run_random(250);
		drain();

		$display("converted %0d beats across %0d epoch settings, %0d results checked",
			n_beats, n_epochs + 1, sb.n_seen);
		$display("mismatches: %0d, left over: %0d", sb.n_err, sb.pending.size());
		if (sb.n_err == 0 && sb.pending.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: civil_mjd_gnss_time_converter_core.f
hw/rtl/cmgt_pkg.sv
hw/rtl/cmgt_civil_path.sv
hw/rtl/cmgt_mjd_path.sv
hw/rtl/civil_mjd_gnss_time_converter_core.sv
tb/testbench.sv
